[sv/rrts_pkg.sv]
// Shared types and constants for the round-robin task scheduler.
package rrts_pkg;

	localparam int TASK_SLOTS = 8;
	localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
	localparam int ID_W       = 4;
	localparam int LEN_W      = 32;
	localparam int STAT_W     = 2;
	localparam int CMP_W      = (CNT_W > ID_W) ? CNT_W : ID_W;

	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 16;

	typedef enum logic [1:0] {
		OP_CREATE   = 2'd0,
		OP_SCHEDULE = 2'd1,
		OP_TICK     = 2'd2,
		OP_SLEEP    = 2'd3
	} op_t;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOMEM = 2'd2;

	typedef enum logic [1:0] {
		CMD_NOP    = 2'd0,
		CMD_CREATE = 2'd1,
		CMD_SLEEP  = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [SLOT_W-1:0]  slot;
		logic [LEN_W-1:0]   length;
	} slot_cmd_t;

endpackage

[sv/rrts_slot_table.sv]
// Per-slot sleep flags and tick counters with one shared decrementer.
module rrts_slot_table (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rrts_pkg::slot_cmd_t                    cmd,
	output logic [rrts_pkg::TASK_SLOTS-1:0]        sleeping
);

	logic [rrts_pkg::TASK_SLOTS-1:0] sleeping_q;
	logic [rrts_pkg::LEN_W-1:0]      counter_q [rrts_pkg::TASK_SLOTS];
	logic [rrts_pkg::LEN_W-1:0]      cur_cnt;
	logic [rrts_pkg::LEN_W-1:0]      dec_cnt;

	// shared decrement unit, saturating at zero
	assign cur_cnt = counter_q[cmd.slot];
	assign dec_cnt = (cur_cnt == '0) ? '0 : cur_cnt - rrts_pkg::LEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleeping_q <= '0;
		end else begin
			unique case (cmd.kind)
				rrts_pkg::CMD_CREATE: sleeping_q[cmd.slot] <= 1'b0;
				rrts_pkg::CMD_SLEEP:  sleeping_q[cmd.slot] <= 1'b1;
				rrts_pkg::CMD_TICK: begin
					if (sleeping_q[cmd.slot] && dec_cnt == '0) begin
						sleeping_q[cmd.slot] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// counters are payload: only read while the slot is sleeping
	always_ff @(posedge clk) begin
		unique case (cmd.kind)
			rrts_pkg::CMD_CREATE: counter_q[cmd.slot] <= '0;
			rrts_pkg::CMD_SLEEP:  counter_q[cmd.slot] <= cmd.length;
			rrts_pkg::CMD_TICK: begin
				if (sleeping_q[cmd.slot]) begin
					counter_q[cmd.slot] <= dec_cnt;
				end
			end
			default: ;
		endcase
	end

	assign sleeping = sleeping_q;

endmodule

[sv/round_robin_task_scheduler.sv]
// Top level of the round-robin task scheduler with sleep timers.
//
// Usage
//   Input stream (s_axis_*): one transaction is one kernel event. tuser holds the
//   operation (create, schedule, tick, sleep); tdata holds stack_available,
//   target_task and sleep_length. Every event gives exactly one result
//   transaction on the output stream (m_axis_*): status, task_id, running_id.
//   Create and sleep go from idle to the hold state; the result then enters the
//   output register once it is free. Schedule walks the slots round robin, one
//   slot per cycle through the ready-flag check, until it finds a ready task or
//   has checked all N tasks in use. Tick sends every slot in use through the single
//   counter decrementer, one slot per cycle. With zero tasks, schedule and tick
//   go straight to the hold state. Throughput: one event at a time; s_axis_tready
//   is high only in idle, so a new event is accepted only once the last leaves hold.
//   The output register parts the two sides: a new event is accepted while an
//   earlier result still waits; the finished result of that event then waits
//   in the hold state until the output register frees up.
//   Reset (arst_n low) empties the task table, marks all slots ready, clears
//   the search point and the running id, and drops m_axis_tvalid.
module round_robin_task_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [0] stack_available, [4:1] target_task, [36:5] sleep_length, [39:37] zero
	input  logic [rrts_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] operation
	input  logic [1:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [1:0] status, [5:2] task_id, [9:6] running_id, [15:10] zero
	output logic [rrts_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_TICK = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	state_t                           state_q;
	logic [rrts_pkg::CNT_W-1:0]       count_q;   // tasks in use
	logic [rrts_pkg::SLOT_W-1:0]      last_q;    // last chosen slot
	logic [rrts_pkg::SLOT_W-1:0]      idx_q;     // scan position
	logic [rrts_pkg::CNT_W-1:0]       step_q;    // slots visited so far
	logic [rrts_pkg::ID_W-1:0]        cur_id_q;  // running task id
	logic [rrts_pkg::STAT_W-1:0]      res_status_q;
	logic [rrts_pkg::ID_W-1:0]        res_id_q;
	logic                             m_valid_q;
	logic [rrts_pkg::M_TDATA_W-1:0]   m_data_q;

	rrts_pkg::op_t                    in_op;
	logic                             in_stack;
	logic [rrts_pkg::ID_W-1:0]        in_target;
	logic [rrts_pkg::LEN_W-1:0]       in_length;
	logic                             in_fire;
	logic                             out_free;
	logic                             sleep_ok;
	logic [rrts_pkg::CMP_W-1:0]       target_ext;
	logic [rrts_pkg::CNT_W-1:0]       idx_inc;
	logic [rrts_pkg::SLOT_W-1:0]      idx_next;
	logic [rrts_pkg::ID_W-1:0]        idx_next_id;
	logic                             last_step;
	rrts_pkg::slot_cmd_t              cmd;
	logic [rrts_pkg::TASK_SLOTS-1:0]  sleeping;

	// unpack the input transaction
	assign in_op     = rrts_pkg::op_t'(s_axis_tuser);
	assign in_stack  = s_axis_tdata[0];
	assign in_target = s_axis_tdata[4:1];
	assign in_length = s_axis_tdata[36:5];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// sleep target must name a task that exists
	assign target_ext = rrts_pkg::CMP_W'(in_target);
	assign sleep_ok   = (in_target != '0)
		&& (target_ext <= rrts_pkg::CMP_W'(count_q))
		&& (target_ext <= rrts_pkg::CMP_W'(rrts_pkg::TASK_SLOTS));

	// round-robin step: next slot, wrapping at the number of tasks in use
	assign idx_inc     = rrts_pkg::CNT_W'(idx_q) + rrts_pkg::CNT_W'(1);
	assign idx_next    = (idx_inc >= count_q) ? '0 : rrts_pkg::SLOT_W'(idx_inc);
	assign idx_next_id = rrts_pkg::ID_W'(rrts_pkg::CMP_W'(idx_next) + rrts_pkg::CMP_W'(1));
	assign last_step   = (step_q == count_q - rrts_pkg::CNT_W'(1));

	// command to the slot table
	always_comb begin
		cmd.kind   = rrts_pkg::CMD_NOP;
		cmd.slot   = '0;
		cmd.length = in_length;
		priority if (state_q == ST_TICK) begin
			cmd.kind = rrts_pkg::CMD_TICK;
			cmd.slot = rrts_pkg::SLOT_W'(step_q);
		end else if (in_fire && in_op == rrts_pkg::OP_CREATE && in_stack
				&& count_q != rrts_pkg::CNT_W'(rrts_pkg::TASK_SLOTS)) begin
			cmd.kind = rrts_pkg::CMD_CREATE;
			cmd.slot = rrts_pkg::SLOT_W'(count_q);
		end else if (in_fire && in_op == rrts_pkg::OP_SLEEP && sleep_ok) begin
			cmd.kind = rrts_pkg::CMD_SLEEP;
			cmd.slot = rrts_pkg::SLOT_W'(rrts_pkg::CMP_W'(target_ext - rrts_pkg::CMP_W'(1)));
		end else begin
		end
	end

	rrts_slot_table u_slot_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sleeping (sleeping)
	);

	// sequencer and task-table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			last_q       <= '0;
			idx_q        <= '0;
			step_q       <= '0;
			cur_id_q     <= '0;
			res_status_q <= rrts_pkg::STAT_OK;
			res_id_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						res_status_q <= rrts_pkg::STAT_OK;
						res_id_q     <= '0;
						step_q       <= '0;
						idx_q        <= last_q;
						state_q      <= ST_HOLD;
						unique case (in_op)
							rrts_pkg::OP_CREATE: begin
								if (count_q == rrts_pkg::CNT_W'(rrts_pkg::TASK_SLOTS)) begin
									res_status_q <= rrts_pkg::STAT_FULL;
								end else if (!in_stack) begin
									res_status_q <= rrts_pkg::STAT_NOMEM;
								end else begin
									count_q  <= count_q + rrts_pkg::CNT_W'(1);
									res_id_q <= rrts_pkg::ID_W'(rrts_pkg::CMP_W'(count_q)
										+ rrts_pkg::CMP_W'(1));
								end
							end
							rrts_pkg::OP_SCHEDULE: begin
								if (count_q == '0) begin
									cur_id_q <= '0;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							rrts_pkg::OP_TICK: begin
								if (count_q != '0) begin
									state_q <= ST_TICK;
								end
							end
							rrts_pkg::OP_SLEEP: ;
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (!sleeping[idx_next]) begin
						last_q   <= idx_next;
						cur_id_q <= idx_next_id;
						res_id_q <= idx_next_id;
						state_q  <= ST_HOLD;
					end else if (last_step) begin
						// no ready task: idle task runs, search point kept
						cur_id_q <= '0;
						res_id_q <= '0;
						state_q  <= ST_HOLD;
					end else begin
						idx_q  <= idx_next;
						step_q <= step_q + rrts_pkg::CNT_W'(1);
					end
				end
				ST_TICK: begin
					step_q <= step_q + rrts_pkg::CNT_W'(1);
					if (last_step) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_HOLD && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			m_data_q <= {6'b0, cur_id_q, res_id_q, res_status_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// scan and tick never run past the tasks in use
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_TICK) |-> (step_q < count_q))
		else $error("sequencer step beyond tasks in use");

	// a create never reaches a full table
	a_no_create_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.kind == rrts_pkg::CMD_CREATE)
			|-> (count_q != rrts_pkg::CNT_W'(rrts_pkg::TASK_SLOTS)))
		else $error("create issued on a full task table");

	// search point always names an existing slot once tasks exist
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (rrts_pkg::CNT_W'(last_q) < count_q))
		else $error("last chosen slot outside the task table");

endmodule
